// File: design/fbpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int ADDR_BITS    = 32;

    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int STRIDE_W     = 16;
    localparam int SIZE_W       = CNT_W + STRIDE_W;
    localparam int ADDR_W       = ADDR_BITS;
    localparam int CMP_W        = ADDR_W + SIZE_W;
    localparam int LINK_W       = CNT_W + 1;

    localparam int FIELD_ADDR_W = 32;
    localparam int FIELD_CNT_W  = 11;
    localparam int STATUS_W     = 3;
    localparam int ACTION_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int OUT_FIELDS_W = STATUS_W + FIELD_ADDR_W + 2 + 2 * FIELD_CNT_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0]   BASE_RST   = ADDR_W'(4096);
    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(16);
    localparam logic [CNT_W-1:0]    COUNT_RST  =
        CNT_W'((MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [STRIDE_W-1:0] stride;
        logic [CNT_W-1:0]    count;
        logic                relink;
    } t_cfg;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                is_null;
        logic                owns;
        logic [SIZE_W-1:0]   off;
    } t_job;

    typedef struct packed {
        logic             live;
        logic [CNT_W-1:0] link;
    } t_link;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [FIELD_ADDR_W-1:0] block_address;
        logic                    inside_pool;
        logic                    at_block_start;
        logic [FIELD_CNT_W-1:0]  free_count;
        logic [FIELD_CNT_W-1:0]  used_count;
        logic                    all_free;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ALLOC_WR,
        BK_FREE_WR,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

// File: design/fbpa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/fbpa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div
    import fbpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SIZE_W-1:0]   i_dividend,
    input  wire logic [STRIDE_W-1:0] i_divisor,
    output logic                     o_done,
    output logic      [SIZE_W-1:0]   o_quotient,
    output logic      [STRIDE_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(SIZE_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [STRIDE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]     r_quo;
    logic [STRIDE_W-1:0]   r_div;
    logic [STRIDE_W:0]     w_cur;
    logic [STRIDE_W+1:0]   w_diff;
    logic                  w_ge;
    logic [STRIDE_W-1:0]   n_rem;

    assign w_cur  = {r_rem, r_quo[SIZE_W-1]};
    assign w_diff = {1'b0, w_cur} - {2'b00, r_div};
    assign w_ge   = !w_diff[STRIDE_W+1];
    assign n_rem  = w_ge ? w_diff[STRIDE_W-1:0] : w_cur[STRIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SIZE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SIZE_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// File: design/fbpa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_front
// Holds the configuration, takes input transactions and checks pool bounds.
// ----------------------------------------------------------------------------
module fbpa_front
    import fbpa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [ACTION_W-1:0]     i_action,
    input  wire logic [FIELD_ADDR_W-1:0] i_address,
    output logic                         o_push,
    output t_job                         o_job,
    input  wire logic                    i_full,
    output t_cfg                         o_cfg
);

    logic [ADDR_W-1:0]      r_base;
    logic [STRIDE_W-1:0]    r_stride;
    logic [CNT_W-1:0]       r_count;
    logic                   r_relink;
    logic [SIZE_W-1:0]      r_size;
    logic                   r_stg_vld;
    logic [ACTION_W-1:0]    r_stg_act;
    logic [ADDR_W-1:0]      r_stg_addr;

    logic [FIELD_CNT_W-1:0] w_cnt_raw;
    logic [CNT_W-1:0]       w_cnt;
    logic [STRIDE_W-1:0]    w_stride;
    logic [SIZE_W-1:0]      w_size;
    logic [ADDR_W:0]        w_diff;
    logic                   w_owns;

    assign w_cnt_raw = i_cfg_data[FIELD_CNT_W-1:0];

    always_comb begin
        if (w_cnt_raw == '0) begin
            w_cnt = CNT_W'(1);
        end else if (32'(w_cnt_raw) > 32'(MAX_BLOCKS)) begin
            w_cnt = CNT_W'(MAX_BLOCKS);
        end else begin
            w_cnt = CNT_W'(w_cnt_raw);
        end
    end

    assign w_stride = (r_stride == '0) ? STRIDE_W'(1) : r_stride;
    assign w_size   = {{STRIDE_W{1'b0}}, r_count} * {{CNT_W{1'b0}}, w_stride};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_RST;
            r_stride  <= STRIDE_RST;
            r_count   <= COUNT_RST;
            r_relink  <= 1'b0;
            r_stg_vld <= 1'b0;
        end else begin
            r_relink <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: begin
                        r_base <= ADDR_W'(i_cfg_data);
                    end
                    CFG_STRIDE: begin
                        r_stride <= i_cfg_data[STRIDE_W-1:0];
                    end
                    CFG_COUNT: begin
                        r_count  <= w_cnt;
                        r_relink <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (o_in_ready) begin
                r_stg_vld <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= w_size;
        if (i_in_valid && o_in_ready) begin
            r_stg_act  <= i_action;
            r_stg_addr <= ADDR_W'(i_address);
        end
    end

    assign w_diff = {1'b0, r_stg_addr} - {1'b0, r_base};
    assign w_owns = (r_stg_addr != '0) && !w_diff[ADDR_W]
                    && (CMP_W'(w_diff[ADDR_W-1:0]) < CMP_W'(r_size));

    assign o_in_ready    = !r_stg_vld || !i_full;
    assign o_push        = r_stg_vld && !i_full;
    assign o_job.action  = r_stg_act;
    assign o_job.is_null = (r_stg_addr == '0);
    assign o_job.owns    = w_owns;
    assign o_job.off     = w_owns ? SIZE_W'(w_diff[ADDR_W-1:0]) : '0;

    assign o_cfg.base    = r_base;
    assign o_cfg.stride  = w_stride;
    assign o_cfg.count   = r_count;
    assign o_cfg.relink  = r_relink;

endmodule
`default_nettype wire

// File: design/fbpa_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_queue
// Short queue of classified transactions between the front and the back.
// ----------------------------------------------------------------------------
module fbpa_queue
    import fbpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("Queue read while empty.");

endmodule
`default_nettype wire

// File: design/fbpa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_back
// Runs allocate, free and query against the free list and the live bits.
// ----------------------------------------------------------------------------
module fbpa_back
    import fbpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_result   o_result
);

    t_back_state         r_state, n_state;
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_mark, n_mark;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_prod, n_prod;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_blk, n_blk;
    logic                r_inside, n_inside;
    logic                r_start, n_start;
    logic                r_out_vld;
    t_result             r_out;

    logic                w_load;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_link               ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    t_link               ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [SIZE_W-1:0]   div_quo;
    logic [STRIDE_W-1:0] div_rem;
    logic [CNT_W-1:0]    w_next;

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_job.off),
        .i_divisor   (i_cfg.stride),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Entries at or above the mark were never handed out, so they still
    // chain to the next index and are not live.
    assign w_next = (r_head == r_mark) ? r_head + CNT_W'(1) : ram_rdata.link;
    assign w_load = (r_state == BK_DONE) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_mark    = r_mark;
        n_free    = r_free;
        n_act     = r_act;
        n_idx     = r_idx;
        n_prod    = r_prod;
        n_status  = r_status;
        n_blk     = r_blk;
        n_inside  = r_inside;
        n_start   = r_start;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_head[IDX_W-1:0];
        div_start = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_act    = i_job.action;
                    n_status = ST_OK;
                    n_blk    = '0;
                    n_inside = 1'b0;
                    n_start  = 1'b0;
                    n_state  = BK_DONE;
                    case (i_job.action)
                        ACT_ALLOC: begin
                            if (r_free == '0 || r_head >= i_cfg.count) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_idx   = r_head[IDX_W-1:0];
                                n_prod  = ADDR_W'({{STRIDE_W{1'b0}}, r_head[IDX_W-1:0]}
                                                  * {{IDX_W{1'b0}}, i_cfg.stride});
                                n_state = BK_ALLOC_WR;
                            end
                        end
                        ACT_FREE: begin
                            if (i_job.is_null) begin
                                n_status = ST_NULL;
                            end else if (!i_job.owns) begin
                                n_status = ST_INVALID;
                            end else begin
                                div_start = 1'b1;
                                n_state   = BK_DIV;
                            end
                        end
                        ACT_QUERY: begin
                            n_inside = i_job.owns;
                            if (i_job.owns) begin
                                div_start = 1'b1;
                                n_state   = BK_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_DONE;
                    if (r_act == ACT_QUERY) begin
                        n_start = (div_rem == '0);
                    end else if (div_rem != '0) begin
                        n_status = ST_INVALID;
                    end else if (div_quo >= SIZE_W'(i_cfg.count)
                                 || div_quo >= SIZE_W'(r_mark)) begin
                        n_status = ST_DOUBLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = div_quo[IDX_W-1:0];
                        n_idx     = div_quo[IDX_W-1:0];
                        n_state   = BK_FREE_WR;
                    end
                end
            end
            BK_ALLOC_WR: begin
                ram_we         = 1'b1;
                ram_wdata.live = 1'b1;
                ram_wdata.link = w_next;
                n_head         = w_next;
                if (r_head == r_mark) begin
                    n_mark = r_mark + CNT_W'(1);
                end
                n_free  = r_free - CNT_W'(1);
                n_blk   = i_cfg.base + r_prod;
                n_state = BK_DONE;
            end
            BK_FREE_WR: begin
                if (!ram_rdata.live) begin
                    n_status = ST_DOUBLE;
                end else begin
                    ram_we         = 1'b1;
                    ram_wdata.live = 1'b0;
                    ram_wdata.link = r_head;
                    n_head         = CNT_W'(r_idx);
                    n_free         = r_free + CNT_W'(1);
                end
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (w_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_head    <= '0;
            r_mark    <= '0;
            r_free    <= COUNT_RST;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.relink) begin
                r_head <= '0;
                r_mark <= '0;
                r_free <= i_cfg.count;
            end else begin
                r_head <= n_head;
                r_mark <= n_mark;
                r_free <= n_free;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_status <= n_status;
        r_blk    <= n_blk;
        r_inside <= n_inside;
        r_start  <= n_start;
        if (w_load) begin
            r_out.status         <= r_status;
            r_out.block_address  <= FIELD_ADDR_W'(r_blk);
            r_out.inside_pool    <= r_inside;
            r_out.at_block_start <= r_start;
            r_out.free_count     <= FIELD_CNT_W'(r_free);
            r_out.used_count     <= FIELD_CNT_W'(i_cfg.count - r_free);
            r_out.all_free       <= (r_free == i_cfg.count);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.relink |-> r_free <= i_cfg.count)
        else $error("Free count exceeds the block count.");

    a_mark_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.relink |-> r_mark <= i_cfg.count)
        else $error("Fill mark exceeds the block count.");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == BK_DONE)
        else $error("Result register loaded outside the done state.");

endmodule
`default_nettype wire

// File: design/fixed_block_pool_allocator_core.sv
`default_nettype none
// Null, unknown or out-of-pool requests and empty allocates go straight to the result, an
// allocate reads and then writes the list memory, and an in-pool query or free waits on the
// 27-step divider; a free that passes its checks then reads and writes the list memory too.
// The back end takes one transaction at a time; front end and queue hold up to 3 more.
// Reset (synchronous, active low) restores the default registers and an all-free list.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block allocator with a LIFO free list and per-block live bits.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: address[31:0].
    input  wire logic [FIELD_ADDR_W-1:0] s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  wire logic [ACTION_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // Fields from bit 0: status[2:0], block_address[34:3], inside_pool[35],
    // at_block_start[36], free_count[47:37], used_count[58:48], all_free[59].
    output logic      [OUT_DATA_W-1:0]   m_axis_tdata
);

    t_cfg    w_cfg;
    t_job    w_front_job;
    t_job    w_queue_job;
    t_result w_result;
    logic    w_push;
    logic    w_full;
    logic    w_queue_vld;
    logic    w_pop;

    fbpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_address   (s_axis_tdata),
        .o_push      (w_push),
        .o_job       (w_front_job),
        .i_full      (w_full),
        .o_cfg       (w_cfg)
    );

    fbpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .o_valid (w_queue_vld),
        .o_job   (w_queue_job),
        .i_pop   (w_pop)
    );

    fbpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_queue_vld),
        .i_job       (w_queue_job),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                           w_result.all_free,
                           w_result.used_count,
                           w_result.free_count,
                           w_result.at_block_start,
                           w_result.inside_pool,
                           w_result.block_address,
                           w_result.status};

endmodule
`default_nettype wire
